// ===== hw/rtl/mmd_pkg.sv =====
// Shared types, constants and helpers of the memory map decoder.
package mmd_pkg;

	// Storage sizes
	localparam int RAM_BYTES = 2097152;
	localparam int SCRATCH_BYTES = 1024;
	localparam int ROM_BYTES = 524288;

	localparam int RAM_DEPTH = RAM_BYTES / 4;
	localparam int SCR_DEPTH = SCRATCH_BYTES / 4;
	localparam int ROM_DEPTH = ROM_BYTES / 4;
	localparam int RAM_AW = $clog2(RAM_DEPTH);
	localparam int SCR_AW = $clog2(SCR_DEPTH);
	localparam int ROM_AW = $clog2(ROM_DEPTH);

	// Request types
	localparam logic [1:0] REQ_READ = 2'd0;
	localparam logic [1:0] REQ_WRITE = 2'd1;
	localparam logic [1:0] REQ_DMA = 2'd2;

	// Access sizes
	localparam logic [1:0] SZ_BYTE = 2'd0;
	localparam logic [1:0] SZ_HALF = 2'd1;
	localparam logic [1:0] SZ_WORD = 2'd2;

	// Region codes
	localparam logic [2:0] RGN_RAM = 3'd0;
	localparam logic [2:0] RGN_ROM = 3'd1;
	localparam logic [2:0] RGN_SCR = 3'd2;
	localparam logic [2:0] RGN_IO = 3'd3;
	localparam logic [2:0] RGN_SPECIAL = 3'd4;
	localparam logic [2:0] RGN_UNMAPPED = 3'd5;
	localparam logic [2:0] RGN_DMA = 3'd6;

	// Memory targets
	localparam logic [1:0] TGT_RAM = 2'd0;
	localparam logic [1:0] TGT_SCR = 2'd1;
	localparam logic [1:0] TGT_ROM = 2'd2;

	// Address windows (low inclusive, high exclusive)
	localparam logic [31:0] RAM_WIN0_LO = 32'h0000_0000;
	localparam logic [31:0] RAM_WIN0_HI = 32'h0080_0000;
	localparam logic [31:0] RAM_WIN1_LO = 32'h8000_0000;
	localparam logic [31:0] RAM_WIN1_HI = 32'h8080_0000;
	localparam logic [31:0] RAM_WIN2_LO = 32'ha000_0000;
	localparam logic [31:0] RAM_WIN2_HI = 32'ha020_0000;
	localparam logic [31:0] ROM_WIN_LO = 32'hbfc0_0000;
	localparam logic [31:0] ROM_WIN_HI = 32'hbfc8_0000;
	localparam logic [31:0] SCR_WIN_LO = 32'h1f80_0000;
	localparam logic [31:0] SCR_WIN_HI = 32'h1f80_0400;
	localparam logic [31:0] IO_WIN_LO = 32'h1f80_1000;
	localparam logic [31:0] IO_WIN_HI = 32'h1f80_4000;
	localparam logic [31:0] SPECIAL_WR_ADDR = 32'hfffe_0130;
	localparam logic [31:0] SPECIAL_RD_ADDR = 32'h1f00_0084;

	// DMA constants
	localparam logic [31:0] OTC_CONTROL = 32'h1100_0002;
	localparam logic [31:0] CHAIN_END = 32'h00ff_ffff;

	// Build-time boot image: uniform fill word
	localparam logic [31:0] ROM_FILL = 32'h0000_0000;

	// Result beat
	typedef struct packed {
		logic [2:0]  region;
		logic [31:0] read_data;
		logic [31:0] io_address;
		logic [31:0] io_data;
		logic        io_is_write;
		logic [1:0]  io_size;
		logic [31:0] dma_final_address;
	} rsp_t;

	// Decoded request
	typedef struct packed {
		logic        mem_op;
		logic        dma_run;
		logic        is_write;
		logic [1:0]  tgt;
		logic [1:0]  size;
		logic [31:0] wdata;
		rsp_t        rsp;
	} dec_t;

	// Memory bank command
	typedef struct packed {
		logic              we;
		logic [1:0]        tgt;
		logic [RAM_AW-1:0] waddr;
		logic [31:0]       wdata;
		logic [RAM_AW-1:0] raddr;
	} mem_cmd_t;

	// Byte lanes covered by an access size
	function automatic logic [31:0] lane_mask(input logic [1:0] size);
		logic [31:0] m;
		case (size)
			SZ_BYTE: m = 32'h0000_00ff;
			SZ_HALF: m = 32'h0000_ffff;
			default: m = 32'hffff_ffff;
		endcase
		return m;
	endfunction

endpackage

// ===== hw/rtl/mmd_req_if.sv =====
// Request channel: bus access or ordering table clear DMA request.
interface mmd_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  req_type;
	logic [31:0] address;
	logic [1:0]  access_size;
	logic [31:0] write_data;
	logic [19:0] word_count;
	logic [31:0] dma_control;

	modport source (
		output valid, req_type, address, access_size, write_data, word_count, dma_control,
		input  ready
	);
	modport sink (
		input  valid, req_type, address, access_size, write_data, word_count, dma_control,
		output ready
	);
endinterface

// ===== hw/rtl/mmd_rsp_if.sv =====
// Result channel: decoded region, read data and forwarded hardware access.
interface mmd_rsp_if;
	logic        valid;
	logic        ready;
	logic [2:0]  region;
	logic [31:0] read_data;
	logic [31:0] io_address;
	logic [31:0] io_data;
	logic        io_is_write;
	logic [1:0]  io_size;
	logic [31:0] dma_final_address;

	modport source (
		output valid, region, read_data, io_address, io_data, io_is_write, io_size,
			dma_final_address,
		input  ready
	);
	modport sink (
		input  valid, region, read_data, io_address, io_data, io_is_write, io_size,
			dma_final_address,
		output ready
	);
endinterface

// ===== hw/rtl/mmd_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
module mmd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== hw/rtl/mmd_decode.sv =====
// Address decoder: maps one request onto a region, a memory target and a result.
module mmd_decode import mmd_pkg::*; (
	input  logic [1:0]  req_type,
	input  logic [31:0] address,
	input  logic [1:0]  access_size,
	input  logic [31:0] write_data,
	input  logic [19:0] word_count,
	input  logic [31:0] dma_control,
	input  logic        cache_isolated,
	output dec_t        dec
);
	logic        is_wr;
	logic        bus_ok;
	logic [31:0] wmasked;
	logic        ram_hit;
	logic        rom_hit;
	logic        scr_hit;
	logic        io_hit;
	logic        spc_hit;

	assign is_wr = (req_type == REQ_WRITE);
	assign bus_ok = (req_type inside {REQ_READ, REQ_WRITE}) &&
		(access_size inside {SZ_BYTE, SZ_HALF, SZ_WORD});
	assign wmasked = write_data & lane_mask(access_size);

	// Window hits; the uncached RAM mirror serves word reads and all writes
	assign ram_hit = (address < RAM_WIN0_HI) ||
		(address >= RAM_WIN1_LO && address < RAM_WIN1_HI) ||
		(address >= RAM_WIN2_LO && address < RAM_WIN2_HI &&
			(is_wr || access_size == SZ_WORD));
	assign rom_hit = !is_wr && address >= ROM_WIN_LO && address < ROM_WIN_HI;
	assign scr_hit = address >= SCR_WIN_LO && address < SCR_WIN_HI;
	assign io_hit = address >= IO_WIN_LO && address < IO_WIN_HI;
	assign spc_hit = (is_wr && access_size == SZ_WORD && address == SPECIAL_WR_ADDR) ||
		(!is_wr && access_size == SZ_BYTE && address == SPECIAL_RD_ADDR);

	// Priority decode
	always_comb begin
		dec = '0;
		dec.rsp.region = RGN_UNMAPPED;
		dec.is_write = is_wr;
		dec.size = access_size;
		dec.wdata = wmasked;
		dec.tgt = TGT_RAM;
		if (req_type == REQ_DMA) begin
			dec.rsp.region = RGN_DMA;
			dec.is_write = 1'b1;
			dec.size = SZ_WORD;
			dec.dma_run = (dma_control == OTC_CONTROL);
			dec.rsp.dma_final_address = dec.dma_run ?
				address - {10'd0, word_count, 2'b00} : address;
		end else if (bus_ok) begin
			if (ram_hit) begin
				dec.rsp.region = RGN_RAM;
				dec.mem_op = !(is_wr && access_size == SZ_WORD && cache_isolated);
			end else if (rom_hit) begin
				dec.rsp.region = RGN_ROM;
				dec.tgt = TGT_ROM;
				dec.mem_op = 1'b1;
			end else if (scr_hit) begin
				dec.rsp.region = RGN_SCR;
				dec.tgt = TGT_SCR;
				dec.mem_op = 1'b1;
			end else if (io_hit) begin
				dec.rsp.region = RGN_IO;
				dec.rsp.io_address = address;
				dec.rsp.io_data = is_wr ? wmasked : 32'd0;
				dec.rsp.io_is_write = is_wr;
				dec.rsp.io_size = access_size;
			end else if (spc_hit) begin
				dec.rsp.region = RGN_SPECIAL;
			end
		end
	end
endmodule

// ===== hw/rtl/mmd_bank.sv =====
// Memory bank: main RAM, scratchpad and boot ROM with the post-reset fill sweep.
module mmd_bank import mmd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  mem_cmd_t    cmd,
	output logic [31:0] rd_data,
	output logic        init_done
);
	logic              clr_q;
	logic [RAM_AW-1:0] sweep_q;
	logic [1:0]        rtgt_q;
	logic              ram_we;
	logic              scr_we;
	logic              rom_we;
	logic [RAM_AW-1:0] waddr;
	logic [31:0]       ram_wdata;
	logic [31:0]       scr_wdata;
	logic [31:0]       ram_rdata;
	logic [31:0]       scr_rdata;
	logic [31:0]       rom_rdata;

	// Sweep every main RAM entry once after reset, wrapping over the smaller memories
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= 1'b1;
			sweep_q <= '0;
		end else if (clr_q) begin
			sweep_q <= sweep_q + RAM_AW'(1);
			if (sweep_q == RAM_AW'(RAM_DEPTH - 1)) begin
				clr_q <= 1'b0;
			end
		end
	end

	assign init_done = !clr_q;

	// Steer the write port between sweep and sequencer
	assign waddr = clr_q ? sweep_q : cmd.waddr;
	assign ram_wdata = clr_q ? 32'd0 : cmd.wdata;
	assign scr_wdata = clr_q ? 32'd0 : cmd.wdata;
	assign ram_we = clr_q || (cmd.we && cmd.tgt == TGT_RAM);
	assign scr_we = clr_q || (cmd.we && cmd.tgt == TGT_SCR);
	assign rom_we = clr_q;

	mmd_ram #(.WIDTH(32), .DEPTH(RAM_DEPTH)) u_main_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (waddr),
		.wdata (ram_wdata),
		.raddr (cmd.raddr),
		.rdata (ram_rdata)
	);

	mmd_ram #(.WIDTH(32), .DEPTH(SCR_DEPTH)) u_scratch_ram (
		.clk   (clk),
		.we    (scr_we),
		.waddr (waddr[SCR_AW-1:0]),
		.wdata (scr_wdata),
		.raddr (cmd.raddr[SCR_AW-1:0]),
		.rdata (scr_rdata)
	);

	mmd_ram #(.WIDTH(32), .DEPTH(ROM_DEPTH)) u_boot_rom (
		.clk   (clk),
		.we    (rom_we),
		.waddr (waddr[ROM_AW-1:0]),
		.wdata (ROM_FILL),
		.raddr (cmd.raddr[ROM_AW-1:0]),
		.rdata (rom_rdata)
	);

	// Track which memory the pending read went to
	always_ff @(posedge clk) begin
		rtgt_q <= cmd.tgt;
	end

	always_comb begin
		case (rtgt_q)
			TGT_SCR: rd_data = scr_rdata;
			TGT_ROM: rd_data = rom_rdata;
			default: rd_data = ram_rdata;
		endcase
	end
endmodule

// ===== hw/rtl/memory_map_decoder_with_otc_dma_core.sv =====
// Top level: request sequencer with read-modify-write byte lane merge and OTC DMA.
// Non-memory accesses go straight to DONE, aligned word writes through WR0, reads through
// RD0, RD1 and MRG, other writes through these then WR0 and WR1. One request is in flight
// at a time. A DMA entry is written directly when word aligned, else via the merge path;
// an aligned entry costs one write on the main RAM port. After reset a fill sweep clears
// RAM and scratchpad and loads the boot image; no request is accepted until it ends,
// configuration writes are taken.
module memory_map_decoder_with_otc_dma_core import mmd_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic         cfg_wdata,
	mmd_req_if.sink      req,
	mmd_rsp_if.source    rsp
);
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_DMA = 3'd1;
	localparam logic [2:0] ST_RD0 = 3'd2;
	localparam logic [2:0] ST_RD1 = 3'd3;
	localparam logic [2:0] ST_MRG = 3'd4;
	localparam logic [2:0] ST_WR0 = 3'd5;
	localparam logic [2:0] ST_WR1 = 3'd6;
	localparam logic [2:0] ST_DONE = 3'd7;

	logic [2:0]        state_q;
	logic              cfg_q;
	logic              out_valid_q;
	rsp_t              out_q;
	rsp_t              res_q;
	dec_t              dec;
	mem_cmd_t          cmd;
	logic [31:0]       rd_data;
	logic              init_done;
	logic              accept;
	logic              fast;
	logic              out_load;
	logic [2:0]        after_wr;

	logic [RAM_AW-1:0] w0_q;
	logic [RAM_AW-1:0] w1;
	logic [1:0]        b_q;
	logic [1:0]        size_q;
	logic [31:0]       wdata_q;
	logic              wr_q;
	logic [1:0]        tgt_q;
	logic              dma_q;
	logic              one_q;
	logic [31:0]       d0_q;
	logic [31:0]       new_lo_q;
	logic [31:0]       new_hi_q;
	logic [RAM_AW+1:0] off_q;
	logic [23:0]       ptr_q;
	logic [19:0]       remain_q;
	logic [31:0]       dma_val;
	logic              dma_direct;

	logic [63:0]       old64;
	logic [63:0]       mask64;
	logic [63:0]       data64;
	logic [63:0]       new64;
	logic [63:0]       shr64;
	logic [31:0]       lmask;

	mmd_decode u_decode (
		.req_type       (req.req_type),
		.address        (req.address),
		.access_size    (req.access_size),
		.write_data     (req.write_data),
		.word_count     (req.word_count),
		.dma_control    (req.dma_control),
		.cache_isolated (cfg_q),
		.dec            (dec)
	);

	mmd_bank u_bank (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.rd_data   (rd_data),
		.init_done (init_done)
	);

	assign req.ready = (state_q == ST_IDLE) && init_done;
	assign accept = req.valid && req.ready;
	assign fast = dec.is_write && dec.size == SZ_WORD && req.address[1:0] == 2'b00;
	assign out_load = (state_q == ST_DONE) && (!out_valid_q || rsp.ready);
	assign after_wr = dma_q ? ST_DMA : ST_DONE;
	assign w1 = w0_q + RAM_AW'(1);

	// DMA entry value; the last entry closes the chain
	assign dma_val = (remain_q == 20'd1) ? CHAIN_END : {8'd0, ptr_q};
	assign dma_direct = (state_q == ST_DMA) && (remain_q != 20'd0) && (off_q[1:0] == 2'b00);

	// Byte lane merge across two adjacent words
	assign lmask = lane_mask(size_q);
	assign old64 = {rd_data, d0_q};
	assign mask64 = {32'd0, lmask} << {b_q, 3'b000};
	assign data64 = {32'd0, wdata_q & lmask} << {b_q, 3'b000};
	assign new64 = (old64 & ~mask64) | data64;
	assign shr64 = old64 >> {b_q, 3'b000};

	// Memory command
	always_comb begin
		cmd.we = dma_direct || state_q == ST_WR0 || state_q == ST_WR1;
		cmd.tgt = tgt_q;
		cmd.raddr = (state_q == ST_RD1) ? w1 : w0_q;
		case (state_q)
			ST_DMA: begin
				cmd.waddr = off_q[RAM_AW+1:2];
				cmd.wdata = dma_val;
			end
			ST_WR1: begin
				cmd.waddr = w1;
				cmd.wdata = new_hi_q;
			end
			default: begin
				cmd.waddr = w0_q;
				cmd.wdata = new_lo_q;
			end
		endcase
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cfg_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				cfg_q <= cfg_wdata;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (dec.dma_run) begin
							state_q <= ST_DMA;
						end else if (dec.mem_op) begin
							state_q <= fast ? ST_WR0 : ST_RD0;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_DMA: begin
					if (remain_q == 20'd0) begin
						state_q <= ST_DONE;
					end else if (off_q[1:0] != 2'b00) begin
						state_q <= ST_RD0;
					end
				end
				ST_RD0: state_q <= ST_RD1;
				ST_RD1: state_q <= ST_MRG;
				ST_MRG: state_q <= wr_q ? ST_WR0 : ST_DONE;
				ST_WR0: state_q <= one_q ? after_wr : ST_WR1;
				ST_WR1: state_q <= after_wr;
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q <= res_q;
		end
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					res_q <= dec.rsp;
					w0_q <= req.address[RAM_AW+1:2];
					b_q <= req.address[1:0];
					size_q <= dec.size;
					wdata_q <= dec.wdata;
					new_lo_q <= dec.wdata;
					wr_q <= dec.is_write;
					tgt_q <= dec.tgt;
					dma_q <= dec.dma_run;
					one_q <= fast;
					ptr_q <= req.address[23:0] - 24'd4;
					if (req.word_count == 20'd0) begin
						off_q <= req.address[RAM_AW+1:0] + (RAM_AW+2)'(4);
						remain_q <= 20'd1;
					end else begin
						off_q <= req.address[RAM_AW+1:0];
						remain_q <= req.word_count;
					end
				end
			end
			ST_DMA: begin
				if (remain_q != 20'd0) begin
					// Advance the chain one entry backward
					off_q <= off_q - (RAM_AW+2)'(4);
					ptr_q <= ptr_q - 24'd4;
					remain_q <= remain_q - 20'd1;
					w0_q <= off_q[RAM_AW+1:2];
					b_q <= off_q[1:0];
					wdata_q <= dma_val;
					one_q <= 1'b0;
				end
			end
			ST_RD1: d0_q <= rd_data;
			ST_MRG: begin
				new_lo_q <= new64[31:0];
				new_hi_q <= new64[63:32];
				if (!wr_q) begin
					res_q.read_data <= shr64[31:0] & lmask;
				end
			end
			default: begin
			end
		endcase
	end

	// Result beat
	assign rsp.valid = out_valid_q;
	assign rsp.region = out_q.region;
	assign rsp.read_data = out_q.read_data;
	assign rsp.io_address = out_q.io_address;
	assign rsp.io_data = out_q.io_data;
	assign rsp.io_is_write = out_q.io_is_write;
	assign rsp.io_size = out_q.io_size;
	assign rsp.dma_final_address = out_q.dma_final_address;
endmodule

// ===== bench/memory_map_decoder_with_otc_dma_core_check.sv =====
`timescale 1ns / 100ps
// Checker for the memory map decoder: mirrors RAM and scratchpad, predicts each result, compares.
module memory_map_decoder_with_otc_dma_core_check import mmd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic cfg_wdata,
	mmd_req_if   req,
	mmd_rsp_if   rsp,
	output int   fail_count,
	output int   in_flight
);

	// Shadow memories; 2-state arrays start at zero, matching the clear after reset
	bit [7:0] ram_img [RAM_BYTES];
	bit [7:0] scr_img [SCRATCH_BYTES];
	bit       isolate;
	rsp_t     awaited_results [$];

	function automatic bit in_window(input logic [31:0] a, input logic [31:0] lo,
			input logic [31:0] hi);
		return (a >= lo) && (a < hi);
	endfunction

	// Little-endian gather; each byte wraps inside its own store
	function automatic logic [31:0] bytes_load(input logic [1:0] tgt, input logic [31:0] addr,
			input int unsigned nbytes);
		logic [31:0] v;
		int unsigned span;
		int unsigned base;
		int unsigned o;
		v = '0;
		span = (tgt == TGT_RAM) ? RAM_BYTES : (tgt == TGT_SCR) ? SCRATCH_BYTES : ROM_BYTES;
		base = addr % span;
		for (int unsigned i = 0; i < nbytes; i++) begin
			o = (base + i) % span;
			case (tgt)
				TGT_RAM: v[8*i +: 8] = ram_img[o];
				TGT_SCR: v[8*i +: 8] = scr_img[o];
				default: v[8*i +: 8] = ROM_FILL[8*(o%4) +: 8];
			endcase
		end
		return v;
	endfunction

	function automatic void bytes_store(input logic [1:0] tgt, input logic [31:0] addr,
			input int unsigned nbytes, input logic [31:0] v);
		int unsigned span;
		int unsigned base;
		int unsigned o;
		span = (tgt == TGT_RAM) ? RAM_BYTES : SCRATCH_BYTES;
		base = addr % span;
		for (int unsigned i = 0; i < nbytes; i++) begin
			o = (base + i) % span;
			if (tgt == TGT_RAM) begin
				ram_img[o] = v[8*i +: 8];
			end else begin
				scr_img[o] = v[8*i +: 8];
			end
		end
	endfunction

	// Decode one request, update the shadow state and return the result it must produce
	function automatic rsp_t decode_access(input logic [1:0] kind, input logic [31:0] addr,
			input logic [1:0] size, input logic [31:0] wdata, input logic [19:0] count,
			input logic [31:0] ctrl);
		rsp_t r;
		int unsigned nbytes;
		int unsigned off;
		logic [31:0] data;
		logic [31:0] link;
		bit wr;
		bit ram_hit;
		r = '0;
		r.region = RGN_UNMAPPED;
		if (kind == REQ_DMA) begin
			r.region = RGN_DMA;
			link = addr;
			if (ctrl == OTC_CONTROL) begin
				// walk down one word per entry, then close the chain on the last one
				off = addr % RAM_BYTES;
				for (int unsigned k = 0; k < count; k++) begin
					link = link - 32'd4;
					bytes_store(TGT_RAM, off, 4, link & CHAIN_END);
					off = (off + RAM_BYTES - 4) % RAM_BYTES;
				end
				bytes_store(TGT_RAM, (off + 4) % RAM_BYTES, 4, CHAIN_END);
			end
			r.dma_final_address = link;
		end else if ((kind == REQ_READ || kind == REQ_WRITE) && size <= SZ_WORD) begin
			wr = (kind == REQ_WRITE);
			nbytes = 1 << size;
			data = (size == SZ_WORD) ? wdata : wdata & ((32'd1 << (8 * nbytes)) - 32'd1);
			// uncached mirror answers byte and halfword reads as unmapped
			ram_hit = in_window(addr, RAM_WIN0_LO, RAM_WIN0_HI) ||
				in_window(addr, RAM_WIN1_LO, RAM_WIN1_HI) ||
				(in_window(addr, RAM_WIN2_LO, RAM_WIN2_HI) && (wr || size == SZ_WORD));
			if (ram_hit) begin
				r.region = RGN_RAM;
				if (!wr) begin
					r.read_data = bytes_load(TGT_RAM, addr, nbytes);
				end else if (!(size == SZ_WORD && isolate)) begin
					bytes_store(TGT_RAM, addr, nbytes, data);
				end
			end else if (!wr && in_window(addr, ROM_WIN_LO, ROM_WIN_HI)) begin
				r.region = RGN_ROM;
				r.read_data = bytes_load(TGT_ROM, addr, nbytes);
			end else if (in_window(addr, SCR_WIN_LO, SCR_WIN_HI)) begin
				r.region = RGN_SCR;
				if (wr) begin
					bytes_store(TGT_SCR, addr, nbytes, data);
				end else begin
					r.read_data = bytes_load(TGT_SCR, addr, nbytes);
				end
			end else if (in_window(addr, IO_WIN_LO, IO_WIN_HI)) begin
				r.region = RGN_IO;
				r.io_address = addr;
				r.io_data = wr ? data : '0;
				r.io_is_write = wr;
				r.io_size = size;
			end else if ((wr && size == SZ_WORD && addr == SPECIAL_WR_ADDR) ||
					(!wr && size == SZ_BYTE && addr == SPECIAL_RD_ADDR)) begin
				r.region = RGN_SPECIAL;
			end
		end
		return r;
	endfunction

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%h, got 0x%h", name, want, got);
			fail_count++;
		end
	endtask

	// Sample both channels and the register port at each rising edge
	always @(posedge clk or negedge arst_n) begin : watch
		rsp_t want;
		if (!arst_n) begin
			isolate = 1'b0;
		end else begin
			if (cfg_we) begin
				isolate = cfg_wdata;
			end
			if (rsp.valid && rsp.ready) begin
				if (awaited_results.size() == 0) begin
					$error("result beat with no request outstanding, region %0d", rsp.region);
					fail_count++;
				end else begin
					want = awaited_results.pop_front();
					check_field("region", want.region, rsp.region);
					check_field("read_data", want.read_data, rsp.read_data);
					check_field("io_address", want.io_address, rsp.io_address);
					check_field("io_data", want.io_data, rsp.io_data);
					check_field("io_is_write", want.io_is_write, rsp.io_is_write);
					check_field("io_size", want.io_size, rsp.io_size);
					check_field("dma_final_address", want.dma_final_address,
						rsp.dma_final_address);
				end
			end
			if (req.valid && req.ready) begin
				awaited_results.push_back(decode_access(req.req_type, req.address,
					req.access_size, req.write_data, req.word_count, req.dma_control));
			end
			in_flight = awaited_results.size();
		end
	end

endmodule

// ===== bench/memory_map_decoder_with_otc_dma_core_test.sv =====
`timescale 1ns / 100ps
// Regression top for the memory map decoder: clock, reset, request and result drivers, verdict.
module memory_map_decoder_with_otc_dma_core_test;
	import mmd_pkg::*;

	localparam int IDLE_LIMIT = 1600000;
	localparam int HOLD_OFF_CYCLES = 400;
	localparam int PHASE_ITEMS = 230;
	localparam int TAIL_CYCLES = 20;
	localparam logic [1:0] REQ_RESERVED = 2'd3;
	localparam logic [1:0] SZ_RESERVED = 2'd3;
	localparam logic [19:0] MAX_WORD_COUNT = 20'd524288;
	localparam logic [31:0] EDGE_ADDRS [12] = '{
		32'h007f_ffff, 32'h0080_0000, 32'h807f_ffff, 32'h8080_0000,
		32'ha01f_ffff, 32'ha020_0000, 32'hbfbf_ffff, 32'hbfc8_0000,
		32'h1f80_03ff, 32'h1f80_0400, 32'h1f80_0fff, 32'h1f80_4000
	};

	typedef enum int {SINK_OPEN, SINK_COIN, SINK_SPARSE, SINK_EVERY4} sink_mode_t;

	typedef struct {
		logic [1:0]  kind;
		logic [31:0] addr;
		logic [1:0]  size;
		logic [31:0] wdata;
		logic [19:0] count;
		logic [31:0] ctrl;
	} bus_req_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic cfg_wdata;
	int   fail_count;
	int   in_flight;
	bit   hold_rsp_req;
	bit   isolate_now;
	int   sent_total;
	int   sent_dma;
	int   sent_isolated;

	mmd_req_if req_ch ();
	mmd_rsp_if rsp_ch ();

	memory_map_decoder_with_otc_dma_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	memory_map_decoder_with_otc_dma_core_check map_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.req        (req_ch),
		.rsp        (rsp_ch),
		.fail_count (fail_count),
		.in_flight  (in_flight)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic bus_req_t make_req(input logic [1:0] kind, input logic [31:0] addr,
			input logic [1:0] size, input logic [31:0] wdata,
			input logic [19:0] count = '0, input logic [31:0] ctrl = OTC_CONTROL);
		bus_req_t r;
		r.kind = kind;
		r.addr = addr;
		r.size = size;
		r.wdata = wdata;
		r.count = count;
		r.ctrl = ctrl;
		return r;
	endfunction

	// RAM offsets that requests keep coming back to: low area, top edge, first words
	function automatic logic [31:0] hot_ram_offset();
		case ($urandom_range(0, 2))
			0: return 32'h0000_0f00 + $urandom_range(0, 511);
			1: return 32'h001f_fe00 + $urandom_range(0, 511);
			default: return $urandom_range(0, 63);
		endcase
	endfunction

	function automatic bus_req_t random_req();
		bus_req_t r;
		int unsigned roll;
		r.kind = $urandom_range(0, 1) ? REQ_WRITE : REQ_READ;
		r.size = 2'($urandom_range(0, 2));
		r.addr = $urandom;
		r.wdata = $urandom;
		r.count = 20'($urandom_range(0, 524288));
		r.ctrl = $urandom;
		roll = $urandom_range(0, 99);
		if (roll < 34) begin
			// RAM through a random mirror, aliasing bits included
			case ($urandom_range(0, 2))
				0: r.addr = ($urandom_range(0, 3) << 21) | hot_ram_offset();
				1: r.addr = RAM_WIN1_LO | ($urandom_range(0, 3) << 21) | hot_ram_offset();
				default: r.addr = RAM_WIN2_LO | hot_ram_offset();
			endcase
		end else if (roll < 40) begin
			r.addr = RAM_WIN0_LO + $urandom_range(0, RAM_WIN0_HI - RAM_WIN0_LO - 1);
		end else if (roll < 48) begin
			r.addr = SCR_WIN_LO + $urandom_range(0, SCRATCH_BYTES - 1);
		end else if (roll < 54) begin
			r.addr = ROM_WIN_LO + $urandom_range(0, ROM_BYTES - 1);
		end else if (roll < 62) begin
			r.addr = IO_WIN_LO + $urandom_range(0, IO_WIN_HI - IO_WIN_LO - 1);
		end else if (roll < 66) begin
			// special words, half exact and half with a wrong kind or size
			r.addr = $urandom_range(0, 1) ? SPECIAL_WR_ADDR : SPECIAL_RD_ADDR;
			if ($urandom_range(0, 1)) begin
				r.kind = (r.addr == SPECIAL_WR_ADDR) ? REQ_WRITE : REQ_READ;
				r.size = (r.addr == SPECIAL_WR_ADDR) ? SZ_WORD : SZ_BYTE;
			end
		end else if (roll < 72) begin
			r.addr = EDGE_ADDRS[$urandom_range(0, 11)];
		end else if (roll < 80) begin
			r.addr = $urandom;
		end else if (roll < 97) begin
			// table clear: mostly a live control word, small counts, some unaligned starts
			r.kind = REQ_DMA;
			r.addr = ($urandom_range(0, 2047) << 21) | hot_ram_offset();
			if ($urandom_range(0, 3) != 0) begin
				r.addr[1:0] = 2'b00;
			end
			r.count = 20'($urandom_range(0, 12));
			case ($urandom_range(0, 4))
				0: r.ctrl = $urandom;
				1: r.ctrl = OTC_CONTROL ^ (32'd1 << $urandom_range(0, 31));
				default: r.ctrl = OTC_CONTROL;
			endcase
		end else begin
			r.addr = hot_ram_offset();
			if ($urandom_range(0, 1)) begin
				r.kind = REQ_RESERVED;
			end else begin
				r.size = SZ_RESERVED;
			end
		end
		return r;
	endfunction

	// Present one beat at the falling edge and hold it until it is taken
	task automatic send_req(input bus_req_t r);
		@(negedge clk);
		req_ch.valid = 1'b1;
		req_ch.req_type = r.kind;
		req_ch.address = r.addr;
		req_ch.access_size = r.size;
		req_ch.write_data = r.wdata;
		req_ch.word_count = r.count;
		req_ch.dma_control = r.ctrl;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		sent_total++;
		if (r.kind == REQ_DMA) begin
			sent_dma++;
		end
		if (isolate_now) begin
			sent_isolated++;
		end
	endtask

	task automatic pause_sender(input int cycles);
		repeat (cycles) begin
			@(negedge clk);
			req_ch.valid = 1'b0;
		end
	endtask

	// Stop offering and wait for every outstanding result
	task automatic drain();
		@(negedge clk);
		req_ch.valid = 1'b0;
		while (in_flight != 0) @(negedge clk);
	endtask

	task automatic write_isolate(input bit v);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_wdata = v;
		@(negedge clk);
		cfg_we = 1'b0;
		isolate_now = v;
	endtask

	task automatic run_random(input int items, input bit hold_off);
		int burst_left;
		burst_left = hold_off ? 60 : 0;
		if (hold_off) begin
			hold_rsp_req = 1'b1;
		end
		for (int i = 0; i < items; i++) begin
			if (burst_left == 0) begin
				pause_sender($urandom_range(1, 12));
				burst_left = $urandom_range(1, 60);
			end
			burst_left--;
			send_req(random_req());
		end
	endtask

	// Result side: ready pattern changes every so often; a long hold-off on request
	initial begin : result_sink
		sink_mode_t mode;
		int mode_left;
		int hold_left;
		int tick;
		mode = SINK_OPEN;
		mode_left = 0;
		hold_left = 0;
		tick = 0;
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			tick++;
			if (hold_rsp_req) begin
				hold_rsp_req = 1'b0;
				hold_left = HOLD_OFF_CYCLES;
			end
			if (mode_left == 0) begin
				mode = sink_mode_t'($urandom_range(0, 3));
				mode_left = $urandom_range(20, 200);
			end
			mode_left--;
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready = 1'b0;
			end else begin
				case (mode)
					SINK_OPEN: rsp_ch.ready = 1'b1;
					SINK_COIN: rsp_ch.ready = 1'($urandom_range(0, 1));
					SINK_SPARSE: rsp_ch.ready = ($urandom_range(0, 4) == 0);
					default: rsp_ch.ready = (tick % 4 == 0);
				endcase
			end
		end
	end

	// Abort when no beat moves on either channel for too long
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < IDLE_LIMIT) begin
			@(posedge clk);
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("no beat moved on either channel for %0d cycles", IDLE_LIMIT);
		$display("memory_map_decoder_with_otc_dma_core regression: fail");
		$finish;
	end

	initial begin : stimulus
		bus_req_t plan [$];
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.req_type = REQ_READ;
		req_ch.address = '0;
		req_ch.access_size = SZ_BYTE;
		req_ch.write_data = '0;
		req_ch.word_count = '0;
		req_ch.dma_control = '0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		write_isolate(1'b0);

		// mirrors, uncached byte read, wrap at the top of RAM
		plan.push_back(make_req(REQ_WRITE, 32'h0000_0010, SZ_WORD, 32'hdead_beef));
		plan.push_back(make_req(REQ_READ, 32'h8000_0010, SZ_WORD, '0));
		plan.push_back(make_req(REQ_READ, 32'ha000_0011, SZ_BYTE, '0));
		plan.push_back(make_req(REQ_READ, 32'ha000_0010, SZ_WORD, '0));
		plan.push_back(make_req(REQ_WRITE, 32'h807f_ffff, SZ_HALF, 32'hffff_a55a));
		plan.push_back(make_req(REQ_READ, 32'h001f_fffe, SZ_WORD, '0));
		// ROM reads, ROM write falls through to unmapped
		plan.push_back(make_req(REQ_READ, 32'hbfc0_0000, SZ_WORD, '0));
		plan.push_back(make_req(REQ_READ, 32'hbfc7_ffff, SZ_BYTE, '0));
		plan.push_back(make_req(REQ_WRITE, 32'hbfc0_0004, SZ_WORD, 32'h5a5a_5a5a));
		// scratchpad with wrap, hardware window
		plan.push_back(make_req(REQ_WRITE, 32'h1f80_03ff, SZ_BYTE, 32'h0000_00c3));
		plan.push_back(make_req(REQ_READ, 32'h1f80_03ff, SZ_HALF, '0));
		plan.push_back(make_req(REQ_WRITE, 32'h1f80_1000, SZ_WORD, 32'hffff_ffff));
		plan.push_back(make_req(REQ_READ, 32'h1f80_3fff, SZ_HALF, 32'hffff_ffff));
		plan.push_back(make_req(REQ_WRITE, 32'h1f80_2001, SZ_BYTE, 32'h1234_56ab));
		// special words, reserved codes, top of the address space
		plan.push_back(make_req(REQ_WRITE, SPECIAL_WR_ADDR, SZ_WORD, 32'h0000_0001));
		plan.push_back(make_req(REQ_READ, SPECIAL_RD_ADDR, SZ_BYTE, '0));
		plan.push_back(make_req(REQ_READ, SPECIAL_RD_ADDR, SZ_WORD, '0));
		plan.push_back(make_req(REQ_READ, 32'h0000_0010, SZ_RESERVED, '0));
		plan.push_back(make_req(REQ_RESERVED, 32'h0000_0010, SZ_WORD, 32'hffff_ffff));
		plan.push_back(make_req(REQ_READ, 32'hffff_ffff, SZ_WORD, '0));
		// table clears: normal, empty, wrong control word, unaligned start
		plan.push_back(make_req(REQ_DMA, 32'h0000_0100, SZ_WORD, '0, 20'd4));
		plan.push_back(make_req(REQ_DMA, 32'h8000_0200, SZ_WORD, '0, 20'd0));
		plan.push_back(make_req(REQ_DMA, 32'h0000_0040, SZ_WORD, '0, 20'd3, 32'hffff_ffff));
		plan.push_back(make_req(REQ_DMA, 32'h0000_0102, SZ_WORD, '0, 20'd3));
		foreach (plan[i]) begin
			send_req(plan[i]);
		end
		drain();

		// cache isolation drops the word write only
		write_isolate(1'b1);
		send_req(make_req(REQ_WRITE, 32'h0000_0010, SZ_WORD, 32'h0bad_f00d));
		send_req(make_req(REQ_WRITE, 32'h0000_0011, SZ_BYTE, 32'h0000_0077));
		send_req(make_req(REQ_READ, 32'h0000_0010, SZ_WORD, '0));
		send_req(make_req(REQ_DMA, 32'h0000_0300, SZ_WORD, '0, 20'd2));
		drain();
		write_isolate(1'b0);

		// one chain as long as RAM itself, then a spot check of its head
		send_req(make_req(REQ_DMA, 32'h001f_fffc, SZ_WORD, '0, MAX_WORD_COUNT));
		send_req(make_req(REQ_READ, 32'h001f_fffc, SZ_WORD, '0));
		drain();

		// random phases, isolation toggled between them, receiver hold-off in one
		for (int p = 0; p < 4; p++) begin
			write_isolate((p % 2) == 0);
			run_random(PHASE_ITEMS, p == 1);
			drain();
		end
		repeat (TAIL_CYCLES) @(negedge clk);

		$display("covered %0d requests: %0d table clears, %0d sent with cache isolation on",
			sent_total, sent_dma, sent_isolated);
		$display("%0d field mismatches or stray results seen", fail_count);
		if (fail_count == 0) begin
			$display("memory_map_decoder_with_otc_dma_core regression: pass");
		end else begin
			$display("memory_map_decoder_with_otc_dma_core regression: fail");
		end
		$finish;
	end

endmodule
